// ===== src/rbit_pkg.sv =====
// Shared types, codes and arithmetic helpers for the rigid body integrate block.
// No dependencies; every other file imports this package.
package rbit_pkg;

    localparam logic [1:0] CMD_LOAD_VERTEX  = 2'd0;
    localparam logic [1:0] CMD_SET_POSE     = 2'd1;
    localparam logic [1:0] CMD_SET_VELOCITY = 2'd2;
    localparam logic [1:0] CMD_STEP         = 2'd3;

    localparam logic [1:0] REG_TIME_STEP       = 2'd0;
    localparam logic [1:0] REG_VERTICES_IN_USE = 2'd1;

    localparam logic [15:0] TIME_STEP_RESET = 16'd1092;
    localparam logic [3:0]  VERTS_RESET     = 4'd4;
    localparam int          EMIT_LIMIT      = 8;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [2:0]         vertex_slot;
        logic signed [31:0] value_x;
        logic signed [31:0] value_y;
        logic signed [31:0] angle_value;
    } t_in_word;

    typedef struct packed {
        logic [2:0]         out_index;
        logic signed [31:0] world_x;
        logic signed [31:0] world_y;
        logic               last;
    } t_out_word;

    // Quarter-wave sine table, Q1.15, 17 points.
    function automatic logic [15:0] qsine(input logic [4:0] idx);
        logic [15:0] v;
        case (idx)
            5'd0:    v = 16'd0;
            5'd1:    v = 16'd3212;
            5'd2:    v = 16'd6393;
            5'd3:    v = 16'd9512;
            5'd4:    v = 16'd12539;
            5'd5:    v = 16'd15446;
            5'd6:    v = 16'd18204;
            5'd7:    v = 16'd20787;
            5'd8:    v = 16'd23170;
            5'd9:    v = 16'd25329;
            5'd10:   v = 16'd27245;
            5'd11:   v = 16'd28898;
            5'd12:   v = 16'd30273;
            5'd13:   v = 16'd31356;
            5'd14:   v = 16'd32137;
            5'd15:   v = 16'd32609;
            default: v = 16'd32767;
        endcase
        return v;
    endfunction

    // u spans 0..16384 (a quarter turn); linear interpolation between points.
    function automatic logic [15:0] quarter_lookup(input logic [14:0] u);
        logic [4:0]  idx;
        logic [9:0]  frac;
        logic [15:0] a;
        logic [15:0] b;
        logic [25:0] prod;
        idx  = u[14:10];
        frac = u[9:0];
        a    = qsine(idx);
        b    = qsine(idx + 5'd1);
        prod = (b - a) * frac;
        if (idx >= 5'd16) begin
            return qsine(5'd16);
        end
        return a + prod[25:10];
    endfunction

    function automatic logic signed [16:0] sine_of(input logic [15:0] ang);
        logic [14:0] u;
        logic [15:0] v;
        if (ang[14]) begin
            u = 15'd16384 - {1'b0, ang[13:0]};
        end else begin
            u = {1'b0, ang[13:0]};
        end
        v = quarter_lookup(u);
        if (ang[15]) begin
            return -$signed({1'b0, v});
        end
        return $signed({1'b0, v});
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sh0000_0000_7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end
        if (x < -64'sh0000_0000_8000_0000) begin
            return 32'sh8000_0000;
        end
        return x[31:0];
    endfunction

endpackage

// ===== src/rbit_in_if.sv =====
// Input channel of the rigid body block: valid, ready and one command word.
// Depends on rbit_pkg for the word type.
interface rbit_in_if;
    import rbit_pkg::*;
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// ===== src/rbit_out_if.sv =====
// Output channel of the rigid body block: valid, ready and one vertex word.
// Depends on rbit_pkg for the word type.
interface rbit_out_if;
    import rbit_pkg::*;
    logic      valid;
    logic      ready;
    t_out_word data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// ===== src/rigid_body_integrate_transform_top.sv =====
// Top level of the 2D rigid body integrator and vertex transform.
// Depends on rbit_pkg, rbit_in_if, rbit_out_if and rbit_trig.
//
// Usage:
//   i_in carries command words (load vertex, set pose, set velocity, step).
//   o_out carries one word per transformed vertex, last set on the final one.
//   The config port (i_cfg_we, i_cfg_index, i_cfg_data) sets time_step and
//   vertices_in_use; write it only while the block is idle.
//   Load, pose and velocity commands are applied when taken; the block stays idle.
//   A step runs the motion update (two multiply/add passes through the
//   integrator), then for each vertex: trig register and vertex memory
//   read, four rotation products, sum and saturate.
//   A step holds the input until the last vertex is in the output register
//   (through the trig state when no vertex is in use), longer if the output stalls.
//   The vertex table is a one-port-write, one-port-read memory with
//   registered read data; it is not cleared at reset.
//   Reset restores position, velocity, heading, spin rate and registers.
//   A stalled receiver holds the output register; the sequencer waits on
//   the next vertex until the register frees, and takes a new command as
//   soon as the last vertex is in the output register.
module rigid_body_integrate_transform_top #(
    parameter int MAX_VERTS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rbit_in_if.sink           i_in,
    rbit_out_if.source        o_out,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data
);
    import rbit_pkg::*;

    localparam int AW  = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1;
    localparam int CAP = (MAX_VERTS < EMIT_LIMIT) ? MAX_VERTS : EMIT_LIMIT;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FMUL = 3'd1;
    localparam logic [2:0] S_VADD = 3'd2;
    localparam logic [2:0] S_PMUL = 3'd3;
    localparam logic [2:0] S_PADD = 3'd4;
    localparam logic [2:0] S_TRIG = 3'd5;
    localparam logic [2:0] S_MUL  = 3'd6;
    localparam logic [2:0] S_ADD  = 3'd7;

    logic [2:0]  r_state;
    logic [15:0] r_dt;
    logic [3:0]  r_viu;
    logic [3:0]  r_k;
    logic [3:0]  w_count;

    logic signed [31:0] r_pos_x, r_pos_y, r_vel_x, r_vel_y, r_spin;
    logic [15:0]        r_heading;
    logic signed [31:0] r_fx, r_fy;
    logic signed [48:0] r_px, r_py, r_ps;
    logic signed [48:0] r_m0, r_m1, r_m2, r_m3;

    logic [63:0] mem [MAX_VERTS];
    logic [63:0] r_rd_data;

    logic        r_out_valid;
    t_out_word   r_out;

    logic signed [16:0] w_sin, w_cos;
    logic               w_accept;
    logic               w_out_free;
    logic signed [63:0] w_wx, w_wy;
    logic signed [31:0] w_lx, w_ly;

    rbit_trig u_trig (
        .i_clk   (i_clk),
        .i_angle (r_heading),
        .o_sin   (w_sin),
        .o_cos   (w_cos)
    );

    assign w_count    = (r_viu > 4'(CAP)) ? 4'(CAP) : r_viu;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    assign w_lx = r_rd_data[31:0];
    assign w_ly = r_rd_data[63:32];
    assign w_wx = 64'(r_pos_x) + ((64'(r_m0) - 64'(r_m1)) >>> 15);
    assign w_wy = 64'(r_pos_y) + ((64'(r_m2) + 64'(r_m3)) >>> 15);

    // Vertex memory: written on load, read at the current vertex each cycle.
    always_ff @(posedge i_clk) begin
        if (w_accept && i_in.data.cmd == CMD_LOAD_VERTEX
                && 32'(i_in.data.vertex_slot) < MAX_VERTS) begin
            mem[AW'(i_in.data.vertex_slot)] <= {i_in.data.value_y, i_in.data.value_x};
        end
        r_rd_data <= mem[AW'(r_k)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt <= TIME_STEP_RESET;
            r_viu <= VERTS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_TIME_STEP:       r_dt <= i_cfg_data;
                REG_VERTICES_IN_USE: r_viu <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_k         <= '0;
            r_pos_x <= '0; r_pos_y <= '0;
            r_vel_x <= '0; r_vel_y <= '0;
            r_spin  <= '0; r_heading <= '0;
        end else begin
            if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        case (i_in.data.cmd)
                            CMD_SET_POSE: begin
                                r_pos_x   <= i_in.data.value_x;
                                r_pos_y   <= i_in.data.value_y;
                                r_heading <= i_in.data.angle_value[15:0];
                            end
                            CMD_SET_VELOCITY: begin
                                r_vel_x <= i_in.data.value_x;
                                r_vel_y <= i_in.data.value_y;
                                r_spin  <= i_in.data.angle_value;
                            end
                            CMD_STEP: begin
                                r_fx    <= i_in.data.value_x;
                                r_fy    <= i_in.data.value_y;
                                r_state <= S_FMUL;
                            end
                            default: ;
                        endcase
                    end
                end
                S_FMUL: begin
                    r_px    <= r_fx * $signed({1'b0, r_dt});
                    r_py    <= r_fy * $signed({1'b0, r_dt});
                    r_ps    <= r_spin * $signed({1'b0, r_dt});
                    r_state <= S_VADD;
                end
                S_VADD: begin
                    r_vel_x <= sat32(64'(r_vel_x) + 64'(r_px >>> 16));
                    r_vel_y <= sat32(64'(r_vel_y) + 64'(r_py >>> 16));
                    r_state <= S_PMUL;
                end
                S_PMUL: begin
                    r_px    <= r_vel_x * $signed({1'b0, r_dt});
                    r_py    <= r_vel_y * $signed({1'b0, r_dt});
                    r_state <= S_PADD;
                end
                S_PADD: begin
                    r_pos_x   <= sat32(64'(r_pos_x) + 64'(r_px >>> 16));
                    r_pos_y   <= sat32(64'(r_pos_y) + 64'(r_py >>> 16));
                    r_heading <= r_heading + r_ps[47:32];
                    r_k       <= '0;
                    r_state   <= S_TRIG;
                end
                S_TRIG: begin
                    // trig register loads the heading here; memory reads the current vertex r_k
                    r_state <= (w_count == 4'd0) ? S_IDLE : S_MUL;
                end
                S_MUL: begin
                    r_m0    <= w_lx * w_cos;
                    r_m1    <= w_ly * w_sin;
                    r_m2    <= w_lx * w_sin;
                    r_m3    <= w_ly * w_cos;
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    // hold until the output register frees
                    if (w_out_free) begin
                        r_out.out_index <= r_k[2:0];
                        r_out.world_x   <= sat32(w_wx);
                        r_out.world_y   <= sat32(w_wy);
                        r_out.last      <= (r_k + 4'd1 == w_count);
                        r_out_valid     <= 1'b1;
                        r_k             <= r_k + 4'd1;
                        r_state         <= (r_k + 4'd1 == w_count) ? S_IDLE : S_TRIG;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_step_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.data.cmd == CMD_STEP) |=> (r_state == S_FMUL))
        else $error("step command did not start integration");

    a_add_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD && r_out_valid && !o_out.ready) |=> (r_state == S_ADD))
        else $error("vertex result advanced over a stalled output");

    a_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL || r_state == S_ADD) |-> (r_k < w_count))
        else $error("vertex index beyond emitted count");

endmodule

// ===== src/rbit_trig.sv =====
// Registered sine and cosine of a 16-bit binary angle.
// Depends on rbit_pkg for the quarter-wave lookup.
module rbit_trig (
    input  logic                i_clk,
    input  logic [15:0]         i_angle,
    output logic signed [16:0]  o_sin,
    output logic signed [16:0]  o_cos
);
    import rbit_pkg::*;

    logic signed [16:0] r_sin;
    logic signed [16:0] r_cos;

    always_ff @(posedge i_clk) begin
        r_sin <= sine_of(i_angle);
        r_cos <= sine_of(i_angle + 16'h4000);
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;
endmodule
